/* hdl/lsch_pkg.sv */
package lsch_pkg;

	// Widths of the fields on the request and result channels.
	localparam int REQ_W      = 2;
	localparam int ID_W       = 8;
	localparam int TK_PORT_W  = 16;
	localparam int RND_W      = 31;
	localparam int IDX_W      = 4;
	localparam int STATUS_W   = 2;
	localparam int WINTK_W    = 20;
	localparam int SLOT_W     = 4;
	localparam int WINS_W     = 32;
	localparam int TOTAL_W    = 20;

	// Widest table address that the block supports.
	localparam int MAX_AW     = 8;

	localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
	localparam logic [REQ_W-1:0] REQ_DRAW   = 2'd1;
	localparam logic [REQ_W-1:0] REQ_READ   = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;
	localparam logic [STATUS_W-1:0] ST_BADIDX = 2'd3;

	typedef struct packed {
		logic                 we;
		logic [MAX_AW-1:0]    addr;
		logic [ID_W-1:0]      id;
		logic [TK_PORT_W-1:0] tickets;
		logic [WINS_W-1:0]    wins;
	} tbl_wr_t;

endpackage

/* hdl/lottery_scheduler.sv */
// Lottery scheduler with a table of clients, their tickets and win counts.
// Requests arrive on the in_valid / in_ready channel: insert a client, draw
// a winner with a supplied random value, or read one entry back. Every
// request gives exactly one result on the out_valid / out_ready channel.
// The block works on one request at a time and holds in_ready low while
// it is busy.
// Insert, the unused code, a read beyond the table and a draw refused for a
// zero total go from execution straight to the output state; a read that
// hits first passes the S_RDW state, as the table memory read is registered.
// A draw runs a bit-serial modulo of the random value by the ticket total,
// one quotient bit a cycle on the shared subtractor, then walks the entries
// from the newest one to the winner; each walk step is one read of the table
// memory and one subtraction on that same unit. A new request is taken only
// once the previous result has entered the output register.
// Reset empties the table (the entry count and the ticket total go to zero)
// and drops any pending result. The result sits in an output register; if
// the receiver stalls, the next request is still accepted and worked on,
// and it waits at its end until the output register is free.
module lottery_scheduler
	import lsch_pkg::*;
#(
	parameter int MAX_CLIENTS = 16,
	parameter int TICKET_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [REQ_W-1:0]      req_type,
	input  logic [ID_W-1:0]       client_id,
	input  logic [TK_PORT_W-1:0]  ticket_count,
	input  logic [RND_W-1:0]      random_value,
	input  logic [IDX_W-1:0]      entry_index,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [STATUS_W-1:0]   status,
	output logic [WINTK_W-1:0]    winning_ticket,
	output logic [SLOT_W-1:0]     winner_slot,
	output logic [ID_W-1:0]       id_out,
	output logic [TK_PORT_W-1:0]  tickets_out,
	output logic [WINS_W-1:0]     wins_out,
	output logic [TOTAL_W-1:0]    total_out
);

	localparam int TW    = (TICKET_BITS < TK_PORT_W) ? TICKET_BITS : TK_PORT_W;
	localparam int AW    = $clog2(MAX_CLIENTS);
	localparam int CW    = $clog2(MAX_CLIENTS + 1);
	localparam int TOT_W = TW + CW;
	localparam int BIT_W = $clog2(RND_W);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_EXEC = 3'd1;
	localparam logic [2:0] S_DIV  = 3'd2;
	localparam logic [2:0] S_WRD  = 3'd3;
	localparam logic [2:0] S_WCHK = 3'd4;
	localparam logic [2:0] S_RDW  = 3'd5;
	localparam logic [2:0] S_OUT  = 3'd6;

	logic [2:0]          state_q;
	logic [REQ_W-1:0]    req_q;
	logic [ID_W-1:0]     id_q;
	logic [TW-1:0]       tk_q;
	logic [RND_W-1:0]    rnd_q;
	logic [IDX_W-1:0]    idx_q;
	logic [CW-1:0]       count_q;
	logic [TOT_W-1:0]    total_q;
	logic [TOT_W-1:0]    rem_q;
	logic [TOT_W-1:0]    win_q;
	logic [BIT_W-1:0]    bit_q;
	logic [CW-1:0]       k_q;

	logic [STATUS_W-1:0]  res_status_q;
	logic [TOT_W-1:0]     res_win_q;
	logic [AW-1:0]        res_slot_q;
	logic [ID_W-1:0]      res_id_q;
	logic [TK_PORT_W-1:0] res_tk_q;
	logic [WINS_W-1:0]    res_wins_q;

	logic                  out_valid_q;
	logic [STATUS_W-1:0]   out_status_q;
	logic [WINTK_W-1:0]    out_win_q;
	logic [SLOT_W-1:0]     out_slot_q;
	logic [ID_W-1:0]       out_id_q;
	logic [TK_PORT_W-1:0]  out_tk_q;
	logic [WINS_W-1:0]     out_wins_q;
	logic [TOTAL_W-1:0]    out_total_q;

	logic                  accept;
	logic                  full;
	logic [AW-1:0]         walk_slot;
	logic [TOT_W:0]        alu_a;
	logic [TOT_W:0]        alu_b;
	logic [TOT_W:0]        alu_diff;
	logic                  alu_borrow;
	logic [TOT_W-1:0]      div_next;
	logic [WINS_W-1:0]     wins_inc;

	tbl_wr_t               tbl_wr;
	logic                  rd_en;
	logic [AW-1:0]         rd_addr;
	logic [ID_W-1:0]       rd_id;
	logic [TW-1:0]         rd_tickets;
	logic [WINS_W-1:0]     rd_wins;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign full      = (count_q == CW'(MAX_CLIENTS));
	assign walk_slot = AW'(k_q - 1'b1);
	assign wins_inc  = (rd_wins == '1) ? rd_wins : rd_wins + 1'b1;

	// The subtractor serves both the restoring division and the walk, where
	// the remaining distance to the winning ticket shrinks by each entry's
	// tickets until it would go negative.
	always_comb begin
		if (state_q == S_DIV) begin
			alu_a = {rem_q, rnd_q[bit_q]};
			alu_b = (TOT_W + 1)'(total_q);
		end else begin
			alu_a = (TOT_W + 1)'(rem_q);
			alu_b = (TOT_W + 1)'(rd_tickets);
		end
	end

	assign div_next = alu_borrow ? alu_a[TOT_W-1:0] : alu_diff[TOT_W-1:0];

	lsch_alu #(
		.W (TOT_W + 1)
	) u_alu (
		.a      (alu_a),
		.b      (alu_b),
		.diff   (alu_diff),
		.borrow (alu_borrow)
	);

	always_comb begin
		tbl_wr  = '0;
		rd_en   = 1'b0;
		rd_addr = '0;
		if (state_q == S_EXEC && req_q == REQ_INSERT && !full) begin
			tbl_wr.we      = 1'b1;
			tbl_wr.addr    = MAX_AW'(count_q[AW-1:0]);
			tbl_wr.id      = id_q;
			tbl_wr.tickets = TK_PORT_W'(tk_q);
			tbl_wr.wins    = '0;
		end else if (state_q == S_WCHK && alu_borrow) begin
			tbl_wr.we      = 1'b1;
			tbl_wr.addr    = MAX_AW'(walk_slot);
			tbl_wr.id      = rd_id;
			tbl_wr.tickets = TK_PORT_W'(rd_tickets);
			tbl_wr.wins    = wins_inc;
		end
		if (state_q == S_EXEC) begin
			rd_en   = 1'b1;
			rd_addr = AW'(idx_q);
		end else if (state_q == S_WRD) begin
			rd_en   = 1'b1;
			rd_addr = walk_slot;
		end
	end

	lsch_table #(
		.DEPTH (MAX_CLIENTS),
		.AW    (AW),
		.TW    (TW)
	) u_table (
		.clk        (clk),
		.wr         (tbl_wr),
		.rd_en      (rd_en),
		.rd_addr    (rd_addr),
		.rd_id      (rd_id),
		.rd_tickets (rd_tickets),
		.rd_wins    (rd_wins)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req_type;
			id_q  <= client_id;
			tk_q  <= ticket_count[TW-1:0];
			rnd_q <= random_value;
			idx_q <= entry_index;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			total_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) state_q <= S_EXEC;
				end
				S_EXEC: begin
					res_status_q <= ST_OK;
					res_win_q    <= '0;
					res_slot_q   <= '0;
					res_id_q     <= '0;
					res_tk_q     <= '0;
					res_wins_q   <= '0;
					state_q      <= S_OUT;
					case (req_q)
						REQ_INSERT: begin
							if (full) begin
								res_status_q <= ST_FULL;
							end else begin
								res_slot_q <= count_q[AW-1:0];
								res_id_q   <= id_q;
								res_tk_q   <= TK_PORT_W'(tk_q);
								count_q    <= count_q + 1'b1;
								total_q    <= total_q + TOT_W'(tk_q);
							end
						end
						REQ_DRAW: begin
							if (total_q == '0) begin
								res_status_q <= ST_EMPTY;
							end else begin
								rem_q   <= '0;
								bit_q   <= BIT_W'(RND_W - 1);
								state_q <= S_DIV;
							end
						end
						REQ_READ: begin
							if (32'(idx_q) >= 32'(count_q)) begin
								res_status_q <= ST_BADIDX;
							end else begin
								res_slot_q <= AW'(idx_q);
								state_q    <= S_RDW;
							end
						end
						default: ;
					endcase
				end
				S_DIV: begin
					rem_q <= div_next;
					bit_q <= bit_q - 1'b1;
					if (bit_q == '0) begin
						win_q   <= div_next;
						k_q     <= count_q;
						state_q <= S_WRD;
					end
				end
				S_WRD: begin
					state_q <= S_WCHK;
				end
				S_WCHK: begin
					if (alu_borrow) begin
						res_win_q  <= win_q;
						res_slot_q <= walk_slot;
						res_id_q   <= rd_id;
						res_tk_q   <= TK_PORT_W'(rd_tickets);
						res_wins_q <= wins_inc;
						state_q    <= S_OUT;
					end else if (k_q == CW'(1)) begin
						// The whole table summed to no more than the ticket;
						// this cannot happen while the total is kept right.
						res_status_q <= ST_EMPTY;
						state_q      <= S_OUT;
					end else begin
						rem_q   <= alu_diff[TOT_W-1:0];
						k_q     <= k_q - 1'b1;
						state_q <= S_WRD;
					end
				end
				S_RDW: begin
					res_id_q   <= rd_id;
					res_tk_q   <= TK_PORT_W'(rd_tickets);
					res_wins_q <= rd_wins;
					state_q    <= S_OUT;
				end
				S_OUT: begin
					if (!out_valid_q || out_ready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_OUT && (!out_valid_q || out_ready)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_OUT && (!out_valid_q || out_ready)) begin
			out_status_q <= res_status_q;
			out_win_q    <= WINTK_W'(res_win_q);
			out_slot_q   <= SLOT_W'(MAX_AW'(res_slot_q));
			out_id_q     <= res_id_q;
			out_tk_q     <= res_tk_q;
			out_wins_q   <= res_wins_q;
			out_total_q  <= TOTAL_W'(total_q);
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = out_status_q;
	assign winning_ticket = out_win_q;
	assign winner_slot    = out_slot_q;
	assign id_out         = out_id_q;
	assign tickets_out    = out_tk_q;
	assign wins_out       = out_wins_q;
	assign total_out      = out_total_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= MAX_CLIENTS)
		else $error("entry count beyond table depth");

	a_rem_below_total: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (rem_q < total_q))
		else $error("partial remainder not below ticket total");

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_EXEC))
		else $error("accepted request not taken into execution");

	a_walk_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WCHK) |-> (k_q != '0 && k_q <= count_q))
		else $error("walk outside the filled part of the table");

endmodule

/* hdl/lsch_alu.sv */
module lsch_alu
	import lsch_pkg::*;
#(
	parameter int W = 22
) (
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	output logic [W-1:0] diff,
	output logic         borrow
);

	// Shared subtractor: a borrow means a is below b.
	assign {borrow, diff} = {1'b0, a} - {1'b0, b};

endmodule

/* hdl/lsch_table.sv */
module lsch_table
	import lsch_pkg::*;
#(
	parameter int DEPTH = 16,
	parameter int AW    = 4,
	parameter int TW    = 16
) (
	input  logic           clk,
	input  tbl_wr_t        wr,
	input  logic           rd_en,
	input  logic [AW-1:0]  rd_addr,
	output logic [ID_W-1:0]   rd_id,
	output logic [TW-1:0]     rd_tickets,
	output logic [WINS_W-1:0] rd_wins
);

	logic [ID_W-1:0]   ids_mem     [DEPTH];
	logic [TW-1:0]     tickets_mem [DEPTH];
	logic [WINS_W-1:0] wins_mem    [DEPTH];

	always_ff @(posedge clk) begin
		if (wr.we) begin
			ids_mem[wr.addr[AW-1:0]]     <= wr.id;
			tickets_mem[wr.addr[AW-1:0]] <= wr.tickets[TW-1:0];
			wins_mem[wr.addr[AW-1:0]]    <= wr.wins;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_id      <= ids_mem[rd_addr];
			rd_tickets <= tickets_mem[rd_addr];
			rd_wins    <= wins_mem[rd_addr];
		end
	end

endmodule

/* dv/tb_lottery_scheduler.sv */
`timescale 1ns / 1ps

module tb_lottery_scheduler;
	import lsch_pkg::*;

	localparam int MAX_CLIENTS = 16;
	localparam int TICKET_BITS = 16;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 100;
	localparam int RANDOM_ITEMS = 1500;
	localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
	localparam logic [TK_PORT_W-1:0] TK_MASK = TK_PORT_W'((64'd1 << TICKET_BITS) - 1);

	typedef struct {
		logic [REQ_W-1:0]     req;
		logic [ID_W-1:0]      id;
		logic [TK_PORT_W-1:0] tk;
		logic [RND_W-1:0]     rnd;
		logic [IDX_W-1:0]     idx;
	} sched_req_t;

	typedef struct {
		logic [STATUS_W-1:0]  status;
		logic [WINTK_W-1:0]   win_tk;
		logic [SLOT_W-1:0]    slot;
		logic [ID_W-1:0]      id;
		logic [TK_PORT_W-1:0] tk;
		logic [WINS_W-1:0]    wins;
		logic [TOTAL_W-1:0]   total;
	} sched_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [REQ_W-1:0] req_type = '0;
	logic [ID_W-1:0] client_id = '0;
	logic [TK_PORT_W-1:0] ticket_count = '0;
	logic [RND_W-1:0] random_value = '0;
	logic [IDX_W-1:0] entry_index = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [STATUS_W-1:0] status;
	logic [WINTK_W-1:0] winning_ticket;
	logic [SLOT_W-1:0] winner_slot;
	logic [ID_W-1:0] id_out;
	logic [TK_PORT_W-1:0] tickets_out;
	logic [WINS_W-1:0] wins_out;
	logic [TOTAL_W-1:0] total_out;

	// Shadow copy of the client table.
	logic [ID_W-1:0] tbl_ids [MAX_CLIENTS];
	logic [TK_PORT_W-1:0] tbl_tickets [MAX_CLIENTS];
	logic [WINS_W-1:0] tbl_wins [MAX_CLIENTS];
	int unsigned tbl_count = 0;
	logic [TOTAL_W-1:0] tbl_total = '0;

	sched_req_t pending_reqs[$];
	sched_res_t expected_results[$];
	sched_req_t cur_req;

	int tx_idle_pct = 0;
	int rx_stall_pct = 0;
	int hold_req = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int cycle_cnt = 0;
	int n_errors = 0;
	int n_accepted = 0;
	int n_checked = 0;
	int n_insert = 0, n_draw = 0, n_read = 0, n_unused = 0;
	int n_full = 0, n_zero_total = 0, n_bad_idx = 0;

	lottery_scheduler #(
		.MAX_CLIENTS(MAX_CLIENTS),
		.TICKET_BITS(TICKET_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.req_type(req_type),
		.client_id(client_id),
		.ticket_count(ticket_count),
		.random_value(random_value),
		.entry_index(entry_index),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.winning_ticket(winning_ticket),
		.winner_slot(winner_slot),
		.id_out(id_out),
		.tickets_out(tickets_out),
		.wins_out(wins_out),
		.total_out(total_out)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Applies one request to the shadow table and returns the result it should give.
	function automatic sched_res_t predict_outcome(sched_req_t r);
		sched_res_t res;
		logic [TK_PORT_W-1:0] tk;
		logic [31:0] win;
		logic [31:0] sum;
		int s;
		res = '{default: '0};
		tk = r.tk & TK_MASK;
		case (r.req)
			REQ_INSERT: begin
				if (tbl_count >= MAX_CLIENTS) begin
					res.status = ST_FULL;
				end else begin
					s = tbl_count;
					tbl_ids[s] = r.id;
					tbl_tickets[s] = tk;
					tbl_wins[s] = '0;
					tbl_count = tbl_count + 1;
					tbl_total = tbl_total + tk;
					res.status = ST_OK;
					res.slot = SLOT_W'(s);
					res.id = r.id;
					res.tk = tk;
				end
			end
			REQ_DRAW: begin
				if (tbl_total == 0) begin
					res.status = ST_EMPTY;
				end else begin
					win = 32'(r.rnd) % 32'(tbl_total);
					sum = 0;
					// Walk from the newest entry back; the full sum always exceeds win.
					for (s = int'(tbl_count) - 1; s >= 0; s--) begin
						sum = sum + tbl_tickets[s];
						if (sum > win) break;
					end
					if (tbl_wins[s] != '1)
						tbl_wins[s] = tbl_wins[s] + 1;
					res.status = ST_OK;
					res.win_tk = WINTK_W'(win);
					res.slot = SLOT_W'(s);
					res.id = tbl_ids[s];
					res.tk = tbl_tickets[s];
					res.wins = tbl_wins[s];
				end
			end
			REQ_READ: begin
				if (r.idx >= tbl_count) begin
					res.status = ST_BADIDX;
				end else begin
					res.status = ST_OK;
					res.slot = r.idx;
					res.id = tbl_ids[r.idx];
					res.tk = tbl_tickets[r.idx];
					res.wins = tbl_wins[r.idx];
				end
			end
			default: res.status = ST_OK;
		endcase
		res.total = tbl_total;
		return res;
	endfunction

	function automatic sched_req_t make_req(logic [REQ_W-1:0] req, logic [ID_W-1:0] id,
			logic [TK_PORT_W-1:0] tk, logic [RND_W-1:0] rnd, logic [IDX_W-1:0] idx);
		sched_req_t r;
		r.req = req;
		r.id = id;
		r.tk = tk;
		r.rnd = rnd;
		r.idx = idx;
		return r;
	endfunction

	// Inserts are kept rare so that the table fills gradually over the first phases.
	function automatic sched_req_t rand_request();
		sched_req_t r;
		int pick;
		pick = $urandom_range(99);
		if (pick < 6)
			r.req = REQ_INSERT;
		else if (pick < 56)
			r.req = REQ_DRAW;
		else if (pick < 94)
			r.req = REQ_READ;
		else
			r.req = REQ_UNUSED;
		r.id = ID_W'($urandom_range(255));
		pick = $urandom_range(9);
		if (pick == 0)
			r.tk = '0;
		else if (pick == 1)
			r.tk = '1;
		else if (pick < 4)
			r.tk = TK_PORT_W'($urandom_range(15, 1));
		else
			r.tk = TK_PORT_W'($urandom_range(65535));
		pick = $urandom_range(9);
		if (pick == 0)
			r.rnd = '0;
		else if (pick == 1)
			r.rnd = '1;
		else if (pick < 4)
			r.rnd = RND_W'($urandom_range(1048575));
		else
			r.rnd = RND_W'($urandom);
		r.idx = IDX_W'($urandom_range(15));
		return r;
	endfunction

	task automatic report_mismatch(input string what, input longint unsigned got,
			input longint unsigned want);
		n_errors++;
		if (n_errors <= 40)
			$display("mismatch at result %0d: %s got 0x%0h, expected 0x%0h",
				n_checked, what, got, want);
	endtask

	task automatic wait_idle();
		wait (pending_reqs.size() == 0 && !in_valid && expected_results.size() == 0);
		@(negedge clk);
	endtask

	task automatic run_phase(input int tx_pct, input int rx_pct, input int n_items,
			input bit with_hold);
		int base;
		tx_idle_pct = tx_pct;
		rx_stall_pct = rx_pct;
		base = n_accepted;
		for (int i = 0; i < n_items; i++)
			pending_reqs.push_back(rand_request());
		if (with_hold) begin
			// The receiver holds off while requests keep coming, so the block backs up.
			wait (n_accepted >= base + 100);
			@(negedge clk);
			hold_req++;
		end
		wait_idle();
	endtask

	always @(posedge clk) begin : drive_requests
		sched_req_t nxt;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				expected_results.push_back(predict_outcome(cur_req));
				n_accepted++;
				case (cur_req.req)
					REQ_INSERT: n_insert++;
					REQ_DRAW: n_draw++;
					REQ_READ: n_read++;
					default: n_unused++;
				endcase
			end
			if (!in_valid || in_ready) begin
				if (pending_reqs.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
					nxt = pending_reqs.pop_front();
					cur_req <= nxt;
					req_type <= nxt.req;
					client_id <= nxt.id;
					ticket_count <= nxt.tk;
					random_value <= nxt.rnd;
					entry_index <= nxt.idx;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : hold_counter
		if (hold_seen != hold_req) begin
			hold_seen <= hold_req;
			hold_left <= HOLD_CYCLES;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	always @(posedge clk) begin : check_results
		sched_res_t want;
		if (arst_n) begin
			if (out_valid === 1'b1 && out_ready) begin
				if (expected_results.size() == 0) begin
					report_mismatch("result with no request outstanding, status", status, 0);
				end else begin
					want = expected_results.pop_front();
					if (status !== want.status)
						report_mismatch("status", status, want.status);
					if (winning_ticket !== want.win_tk)
						report_mismatch("winning_ticket", winning_ticket, want.win_tk);
					if (winner_slot !== want.slot)
						report_mismatch("winner_slot", winner_slot, want.slot);
					if (id_out !== want.id)
						report_mismatch("id_out", id_out, want.id);
					if (tickets_out !== want.tk)
						report_mismatch("tickets_out", tickets_out, want.tk);
					if (wins_out !== want.wins)
						report_mismatch("wins_out", wins_out, want.wins);
					if (total_out !== want.total)
						report_mismatch("total_out", total_out, want.total);
					case (want.status)
						ST_FULL: n_full++;
						ST_EMPTY: n_zero_total++;
						ST_BADIDX: n_bad_idx++;
						default: ;
					endcase
					n_checked++;
				end
			end
			out_ready <= (hold_left == 0) && ($urandom_range(99) >= rx_stall_pct);
		end
	end

	always @(posedge clk) begin : watchdog
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles with %0d results outstanding",
				cycle_cnt, expected_results.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed requests: empty table, zero-ticket client, extreme tickets and
		// random values, newest and oldest winners, reads inside and beyond the table.
		pending_reqs.push_back(make_req(REQ_DRAW, 8'h00, 16'h0000, '1, 4'd0));
		pending_reqs.push_back(make_req(REQ_READ, 8'h00, 16'h0000, '0, 4'd0));
		pending_reqs.push_back(make_req(REQ_UNUSED, '1, '1, '1, '1));
		pending_reqs.push_back(make_req(REQ_INSERT, 8'h00, 16'h0000, '0, 4'd0));
		pending_reqs.push_back(make_req(REQ_DRAW, 8'h11, 16'h0000, 31'd12345, 4'd0));
		pending_reqs.push_back(make_req(REQ_READ, 8'h00, 16'h0000, '0, 4'd0));
		pending_reqs.push_back(make_req(REQ_READ, 8'h00, 16'h0000, '0, 4'd1));
		pending_reqs.push_back(make_req(REQ_INSERT, 8'hFF, 16'hFFFF, '0, 4'd0));
		pending_reqs.push_back(make_req(REQ_DRAW, 8'h00, 16'h0000, '0, 4'd0));
		pending_reqs.push_back(make_req(REQ_DRAW, 8'h00, 16'h0000, '1, 4'd0));
		pending_reqs.push_back(make_req(REQ_INSERT, 8'h5A, 16'h0001, '0, 4'd0));
		pending_reqs.push_back(make_req(REQ_DRAW, 8'h00, 16'h0000, '0, 4'd0));
		pending_reqs.push_back(make_req(REQ_DRAW, 8'h00, 16'h0000, 31'd65535, 4'd0));
		pending_reqs.push_back(make_req(REQ_INSERT, 8'hA5, 16'h8000, '1, '1));
		pending_reqs.push_back(make_req(REQ_READ, 8'h00, 16'h0000, '0, 4'd3));
		pending_reqs.push_back(make_req(REQ_READ, 8'h00, 16'h0000, '0, 4'd4));
		pending_reqs.push_back(make_req(REQ_READ, '1, '1, '1, 4'd15));
		pending_reqs.push_back(make_req(REQ_READ, 8'h00, 16'h0000, '0, 4'd1));
		pending_reqs.push_back(make_req(REQ_UNUSED, 8'h00, 16'h0000, '0, 4'd0));
		wait_idle();

		run_phase(0, 0, RANDOM_ITEMS / 4, 1'b1);
		run_phase(69, 0, RANDOM_ITEMS / 4, 1'b0);
		run_phase(0, 69, RANDOM_ITEMS / 4, 1'b0);
		run_phase(19, 19, RANDOM_ITEMS / 4, 1'b0);

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("covered %0d requests: %0d inserts, %0d draws, %0d reads, %0d unused codes",
			n_accepted, n_insert, n_draw, n_read, n_unused);
		$display("%0d results checked; full table %0d, zero total %0d, bad index %0d times",
			n_checked, n_full, n_zero_total, n_bad_idx);
		if (n_errors == 0 && expected_results.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("%0d mismatches, %0d results never arrived", n_errors,
				expected_results.size());
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
